[hw/rtl/ucs_pkg.sv]
// Shared types and constants for the URI component splitter.
// Holds character codes, state and component codes, and the result word layout.
// No dependencies.
package ucs_pkg;

    localparam int OFS_W = 16;

    localparam logic       OP_CHAR = 1'b0;
    localparam logic       OP_END  = 1'b1;

    localparam logic       KIND_SPAN    = 1'b0;
    localparam logic       KIND_VERDICT = 1'b1;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;

    localparam logic [3:0] T_START  = 4'd0;
    localparam logic [3:0] T_SCHEME = 4'd1;
    localparam logic [3:0] T_HIER   = 4'd2;
    localparam logic [3:0] T_QMARK  = 4'd3;
    localparam logic [3:0] T_QUERY  = 4'd4;
    localparam logic [3:0] T_HASHED = 4'd5;
    localparam logic [3:0] T_FRAG   = 4'd6;

    localparam logic [2:0] H_START  = 3'd0;
    localparam logic [2:0] H_SLASH1 = 3'd1;
    localparam logic [2:0] H_SLASH2 = 3'd2;
    localparam logic [2:0] H_AUTH   = 3'd3;
    localparam logic [2:0] H_PATH   = 3'd4;
    localparam logic [2:0] H_FIN    = 3'd5;

    localparam logic [2:0] A_START  = 3'd0;
    localparam logic [2:0] A_USER   = 3'd1;
    localparam logic [2:0] A_AT     = 3'd2;
    localparam logic [2:0] A_HOST   = 3'd3;
    localparam logic [2:0] A_COLON  = 3'd4;
    localparam logic [2:0] A_PORT   = 3'd5;
    localparam logic [2:0] A_FIN    = 3'd6;

    localparam logic [2:0] C_SCHEME = 3'd0;
    localparam logic [2:0] C_USER   = 3'd1;
    localparam logic [2:0] C_HOST   = 3'd2;
    localparam logic [2:0] C_PORT   = 3'd3;
    localparam logic [2:0] C_PATH   = 3'd4;
    localparam logic [2:0] C_QUERY  = 3'd5;
    localparam logic [2:0] C_FRAG   = 3'd6;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef struct packed {
        logic             kind;
        logic [2:0]       component;
        logic [OFS_W-1:0] span_start;
        logic [OFS_W-1:0] span_end;
        logic             uri_valid;
        logic [OFS_W-1:0] error_offset;
        logic             last_result;
    } result_t;

    // Up to two result words produced by one input word.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

[hw/rtl/ucs_parser.sv]
// Three-level URI state machine: tracks position, emits spans and the verdict.
// Depends on ucs_pkg for codes and the result word layout.
module ucs_parser #(
    parameter int POS_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic                 operation,
    input  logic [7:0]           char_code,
    output ucs_pkg::push_t       push
);

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam logic [POS_BITS-1:0] POS_ONE = {{(POS_BITS-1){1'b0}}, 1'b1};

    logic [3:0]          top_reg, top_next;
    logic [2:0]          hier_reg, hier_next;
    logic [2:0]          auth_reg, auth_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] mark_reg, mark_next;
    logic                fail_reg, fail_next;
    logic [POS_BITS-1:0] fpos_reg, fpos_next;

    logic                span_en;
    logic [2:0]          span_comp;
    logic                verdict_en;
    logic                verdict_ok;
    logic [POS_BITS-1:0] verdict_err;
    ucs_pkg::result_t    span_res;
    ucs_pkg::result_t    verdict_res;

    function automatic logic [ucs_pkg::OFS_W-1:0] to_ofs(input logic [POS_BITS-1:0] v);
        logic [POS_BITS+ucs_pkg::OFS_W-1:0] w;
        w = {{ucs_pkg::OFS_W{1'b0}}, v};
        return w[ucs_pkg::OFS_W-1:0];
    endfunction

    always_comb
    begin
        top_next    = top_reg;
        hier_next   = hier_reg;
        auth_next   = auth_reg;
        pos_next    = pos_reg;
        mark_next   = mark_reg;
        fail_next   = fail_reg;
        fpos_next   = fpos_reg;
        span_en     = 1'b0;
        span_comp   = ucs_pkg::C_SCHEME;
        verdict_en  = 1'b0;
        verdict_ok  = 1'b1;
        verdict_err = '0;

        if (fire && operation == ucs_pkg::OP_CHAR)
        begin
            if (fail_reg)
            begin
                // drop characters after a failure
            end
            else if (pos_reg == POS_MAX)
            begin
                fail_next = 1'b1;
                fpos_next = POS_MAX;
            end
            else
            begin
                pos_next = pos_reg + POS_ONE;
                unique case (top_reg) inside
                    ucs_pkg::T_START, ucs_pkg::T_SCHEME:
                    begin
                        top_next = ucs_pkg::T_SCHEME;
                        if (char_code == ucs_pkg::CH_COLON)
                        begin
                            span_en   = 1'b1;
                            span_comp = ucs_pkg::C_SCHEME;
                            mark_next = pos_reg;
                            top_next  = ucs_pkg::T_HIER;
                        end
                    end
                    ucs_pkg::T_HIER:
                    begin
                        unique case (hier_reg)
                            ucs_pkg::H_START:
                            begin
                                if (char_code == ucs_pkg::CH_SLASH)
                                    hier_next = ucs_pkg::H_SLASH1;
                                else
                                begin
                                    mark_next = pos_reg;
                                    hier_next = ucs_pkg::H_PATH;
                                end
                            end
                            ucs_pkg::H_SLASH1:
                            begin
                                if (char_code == ucs_pkg::CH_SLASH)
                                    hier_next = ucs_pkg::H_SLASH2;
                                else
                                begin
                                    fail_next = 1'b1;
                                    fpos_next = pos_reg;
                                end
                            end
                            ucs_pkg::H_SLASH2:
                            begin
                                mark_next = pos_reg;
                                if (char_code == ucs_pkg::CH_SLASH)
                                    hier_next = ucs_pkg::H_PATH;
                                else
                                begin
                                    hier_next = ucs_pkg::H_AUTH;
                                    auth_next = ucs_pkg::A_USER;
                                end
                            end
                            ucs_pkg::H_AUTH:
                            begin
                                unique case (auth_reg) inside
                                    ucs_pkg::A_USER, ucs_pkg::A_HOST, ucs_pkg::A_PORT:
                                    begin
                                        span_comp = (auth_reg == ucs_pkg::A_PORT) ?
                                                    ucs_pkg::C_PORT : ucs_pkg::C_HOST;
                                        if (char_code == ucs_pkg::CH_AT &&
                                            auth_reg == ucs_pkg::A_USER)
                                        begin
                                            span_en   = 1'b1;
                                            span_comp = ucs_pkg::C_USER;
                                            auth_next = ucs_pkg::A_AT;
                                        end
                                        else if (char_code == ucs_pkg::CH_COLON &&
                                                 auth_reg != ucs_pkg::A_PORT)
                                        begin
                                            span_en   = 1'b1;
                                            auth_next = ucs_pkg::A_COLON;
                                        end
                                        else if (char_code == ucs_pkg::CH_SLASH)
                                        begin
                                            // path opens at the slash
                                            span_en   = 1'b1;
                                            mark_next = pos_reg;
                                            auth_next = ucs_pkg::A_FIN;
                                            hier_next = ucs_pkg::H_PATH;
                                        end
                                        else if (char_code == ucs_pkg::CH_QUEST ||
                                                 char_code == ucs_pkg::CH_HASH)
                                        begin
                                            span_en   = 1'b1;
                                            auth_next = ucs_pkg::A_FIN;
                                            hier_next = ucs_pkg::H_FIN;
                                            top_next  = (char_code == ucs_pkg::CH_QUEST) ?
                                                        ucs_pkg::T_QMARK : ucs_pkg::T_HASHED;
                                        end
                                    end
                                    ucs_pkg::A_AT:
                                    begin
                                        mark_next = pos_reg;
                                        auth_next = ucs_pkg::A_HOST;
                                    end
                                    ucs_pkg::A_COLON:
                                    begin
                                        mark_next = pos_reg;
                                        auth_next = ucs_pkg::A_PORT;
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                            ucs_pkg::H_PATH:
                            begin
                                if (char_code == ucs_pkg::CH_QUEST ||
                                    char_code == ucs_pkg::CH_HASH)
                                begin
                                    span_en   = 1'b1;
                                    span_comp = ucs_pkg::C_PATH;
                                    hier_next = ucs_pkg::H_FIN;
                                    top_next  = (char_code == ucs_pkg::CH_QUEST) ?
                                                ucs_pkg::T_QMARK : ucs_pkg::T_HASHED;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    ucs_pkg::T_QMARK:
                    begin
                        mark_next = pos_reg;
                        top_next  = ucs_pkg::T_QUERY;
                    end
                    ucs_pkg::T_QUERY:
                    begin
                        if (char_code == ucs_pkg::CH_HASH)
                        begin
                            span_en   = 1'b1;
                            span_comp = ucs_pkg::C_QUERY;
                            top_next  = ucs_pkg::T_HASHED;
                        end
                    end
                    ucs_pkg::T_HASHED:
                    begin
                        mark_next = pos_reg;
                        top_next  = ucs_pkg::T_FRAG;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (fire)
        begin
            verdict_en = 1'b1;
            if (fail_reg)
            begin
                verdict_ok  = 1'b0;
                verdict_err = fpos_reg;
            end
            else if (top_reg == ucs_pkg::T_SCHEME)
            begin
                verdict_ok  = 1'b0;
                verdict_err = pos_reg;
            end
            else if (top_reg == ucs_pkg::T_HIER)
            begin
                if (hier_reg == ucs_pkg::H_START || hier_reg == ucs_pkg::H_SLASH1 ||
                    hier_reg == ucs_pkg::H_SLASH2)
                begin
                    verdict_ok  = 1'b0;
                    verdict_err = pos_reg;
                end
                else if (hier_reg == ucs_pkg::H_AUTH)
                begin
                    if (auth_reg == ucs_pkg::A_USER || auth_reg == ucs_pkg::A_HOST)
                    begin
                        span_en   = 1'b1;
                        span_comp = ucs_pkg::C_HOST;
                    end
                    else if (auth_reg == ucs_pkg::A_PORT)
                    begin
                        span_en   = 1'b1;
                        span_comp = ucs_pkg::C_PORT;
                    end
                end
                else if (hier_reg == ucs_pkg::H_PATH)
                begin
                    span_en   = 1'b1;
                    span_comp = ucs_pkg::C_PATH;
                end
            end
            else if (top_reg == ucs_pkg::T_QUERY)
            begin
                span_en   = 1'b1;
                span_comp = ucs_pkg::C_QUERY;
            end
            else if (top_reg == ucs_pkg::T_FRAG)
            begin
                span_en   = 1'b1;
                span_comp = ucs_pkg::C_FRAG;
            end
            // back to the reset state for the next URI
            top_next  = ucs_pkg::T_START;
            hier_next = ucs_pkg::H_START;
            auth_next = ucs_pkg::A_START;
            pos_next  = '0;
            mark_next = '0;
            fail_next = 1'b0;
            fpos_next = '0;
        end
    end

    always_comb
    begin
        span_res.kind         = ucs_pkg::KIND_SPAN;
        span_res.component    = span_comp;
        span_res.span_start   = to_ofs(mark_reg);
        span_res.span_end     = to_ofs(pos_reg);
        span_res.uri_valid    = 1'b0;
        span_res.error_offset = '0;
        span_res.last_result  = !verdict_en;

        verdict_res.kind         = ucs_pkg::KIND_VERDICT;
        verdict_res.component    = ucs_pkg::C_SCHEME;
        verdict_res.span_start   = '0;
        verdict_res.span_end     = '0;
        verdict_res.uri_valid    = verdict_ok;
        verdict_res.error_offset = to_ofs(verdict_err);
        verdict_res.last_result  = 1'b1;

        push.res1 = verdict_res;
        if (span_en)
            push.res0 = span_res;
        else
            push.res0 = verdict_res;
        push.count = {1'b0, span_en} + {1'b0, verdict_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= ucs_pkg::T_START;
            hier_reg <= ucs_pkg::H_START;
            auth_reg <= ucs_pkg::A_START;
            pos_reg  <= '0;
            mark_reg <= '0;
            fail_reg <= 1'b0;
            fpos_reg <= '0;
        end
        else
        begin
            top_reg  <= top_next;
            hier_reg <= hier_next;
            auth_reg <= auth_next;
            pos_reg  <= pos_next;
            mark_reg <= mark_next;
            fail_reg <= fail_next;
            fpos_reg <= fpos_next;
        end
    end

endmodule

[hw/rtl/uri_component_splitter_top.sv]
// Top level of the URI component splitter: parser plus a small result queue.
// Depends on ucs_pkg and ucs_parser.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | into      | in_valid / in_stall | operation, char_code
//  out     | out of    | out_valid/out_stall | kind, component, span_start, span_end,
//          |           |                     | uri_valid, error_offset, last_result
//
// One input word per cycle unless in_stall is high; the parser state updates in the cycle the word is taken.
// A character gives at most one result word, an end word one or two, queued in a four-entry
// result queue that registers each result word before the out channel shows it.
// in_stall rises when the queue has fewer than two free entries.
// Reset returns the parser to the start state and empties the queue.
module uri_component_splitter_top #(
    parameter int POS_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [2:0]  component,
    output logic [15:0] span_start,
    output logic [15:0] span_end,
    output logic        uri_valid,
    output logic [15:0] error_offset,
    output logic        last_result
);

    localparam logic [ucs_pkg::QCNT_W-1:0] STALL_AT =
        ucs_pkg::QCNT_W'(ucs_pkg::QDEPTH - 1);
    localparam logic [ucs_pkg::QPTR_W-1:0] PTR_ONE =
        ucs_pkg::QPTR_W'(1);

    ucs_pkg::push_t              push;
    ucs_pkg::result_t            q_reg [ucs_pkg::QDEPTH];
    ucs_pkg::result_t            head;
    logic [ucs_pkg::QPTR_W-1:0]  wr_reg, wr_next;
    logic [ucs_pkg::QPTR_W-1:0]  rd_reg, rd_next;
    logic [ucs_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;
    logic                        fire;
    logic                        pop;

    assign in_stall = (cnt_reg >= STALL_AT);
    assign fire     = in_valid && !in_stall;
    assign out_valid = (cnt_reg != '0);
    assign pop      = out_valid && !out_stall;

    ucs_parser #(
        .POS_BITS (POS_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .operation (operation),
        .char_code (char_code),
        .push      (push)
    );

    always_comb
    begin
        wr_next  = wr_reg + push.count[ucs_pkg::QPTR_W-1:0];
        rd_next  = pop ? (rd_reg + PTR_ONE) : rd_reg;
        cnt_next = cnt_reg + ucs_pkg::QCNT_W'(push.count) - ucs_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            q_reg[wr_reg] <= push.res0;
        if (push.count == 2'd2)
            q_reg[wr_reg + PTR_ONE] <= push.res1;
    end

    assign head         = q_reg[rd_reg];
    assign kind         = head.kind;
    assign component    = head.component;
    assign span_start   = head.span_start;
    assign span_end     = head.span_end;
    assign uri_valid    = head.uri_valid;
    assign error_offset = head.error_offset;
    assign last_result  = head.last_result;

endmodule

[hw/rtl/ucs_checker.sv]
// Port-level checks for the URI component splitter, bound to the top level.
// Depends on ucs_pkg for the result kind codes.
module ucs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        kind,
    input logic [15:0] span_start,
    input logic [15:0] span_end,
    input logic        uri_valid,
    input logic [15:0] error_offset,
    input logic        last_result
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(span_end) && $stable(kind))
        else $error("result word dropped while stalled");

    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == ucs_pkg::KIND_VERDICT |-> last_result)
        else $error("verdict word not marked last");

    // a word followed by more of the same item is always a span before the verdict
    a_not_last_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> kind == ucs_pkg::KIND_SPAN)
        else $error("non-last word is not a span");

    a_span_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == ucs_pkg::KIND_SPAN |-> !uri_valid && error_offset == 16'd0)
        else $error("span word carries verdict fields");

    a_valid_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && uri_valid |-> error_offset == 16'd0 && span_start == 16'd0)
        else $error("valid verdict carries an error offset");

endmodule

bind uri_component_splitter_top ucs_checker u_ucs_checker (.*);
